### rtl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and constants for the countdown timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package mtt_pkg;

	localparam int NumTimers = 32;
	localparam int SlotCap   = 32;
	localparam int NumSlots  = (NumTimers < SlotCap) ? NumTimers : SlotCap;
	localparam int PosW      = (NumSlots > 1) ? $clog2(NumSlots) : 1;

	localparam int OpW    = 3;
	localparam int IdxW   = 5;
	localparam int ByteW  = 8;
	localparam int CountW = 32;
	localparam int KindW  = 2;
	localparam int StatW  = 2;

	typedef enum logic [OpW-1:0] {
		OP_ALLOC    = 3'd0,
		OP_FREE     = 3'd1,
		OP_INIT     = 3'd2,
		OP_SET_TIME = 3'd3,
		OP_TICK     = 3'd4
	} op_t;

	typedef enum logic [KindW-1:0] {
		KIND_ALLOC  = 2'd0,
		KIND_ACK    = 2'd1,
		KIND_EXPIRE = 2'd2
	} kind_t;

	typedef enum logic [StatW-1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_FREE   = 2'd1,
		STAT_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SLOT_FREE  = 2'd0,
		SLOT_ALLOC = 2'd1,
		SLOT_RUN   = 2'd2
	} slot_state_t;

	typedef struct packed {
		slot_state_t       state;
		logic [CountW-1:0] remaining;
		logic [ByteW-1:0]  dest;
		logic [ByteW-1:0]  data;
	} slot_rec_t;

	typedef struct packed {
		logic [OpW-1:0]    op;
		logic              hit;
		logic              found;
		logic [ByteW-1:0]  dest;
		logic [ByteW-1:0]  data;
		logic [CountW-1:0] timeout;
	} head_cmd_t;

	typedef struct packed {
		logic claim;
		logic expire;
	} head_flags_t;

endpackage

`default_nettype wire

### rtl/mtt_cell.sv
// ----------------------------------------------------------------------------
// mtt_cell
// One stage of the slot ring: holds a slot record and takes its neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  shift,
	input  mtt_pkg::slot_rec_t   rec_in,
	output mtt_pkg::slot_rec_t   rec_out
);

	mtt_pkg::slot_state_t              state_q;
	logic [mtt_pkg::CountW-1:0]        remaining_q;
	logic [mtt_pkg::ByteW-1:0]         dest_q;
	logic [mtt_pkg::ByteW-1:0]         data_q;

	// slot state must come up free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtt_pkg::SLOT_FREE;
		end else if (shift) begin
			state_q <= rec_in.state;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			remaining_q <= rec_in.remaining;
			dest_q      <= rec_in.dest;
			data_q      <= rec_in.data;
		end
	end

	assign rec_out.state     = state_q;
	assign rec_out.remaining = remaining_q;
	assign rec_out.dest      = dest_q;
	assign rec_out.data      = data_q;

endmodule

`default_nettype wire

### rtl/mtt_head.sv
// ----------------------------------------------------------------------------
// mtt_head
// Update of the head-of-ring slot record, one slot per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_head (
	input  mtt_pkg::head_cmd_t   cmd,
	input  mtt_pkg::slot_rec_t   rec_in,
	output mtt_pkg::slot_rec_t   rec_out,
	output mtt_pkg::head_flags_t flags
);

	logic [mtt_pkg::CountW-1:0] dec;

	assign dec = rec_in.remaining - mtt_pkg::CountW'(1);

	always_comb begin
		rec_out = rec_in;
		flags   = '0;
		case (cmd.op)
			mtt_pkg::OP_ALLOC: begin
				// first free slot seen on this pass
				if (!cmd.found && rec_in.state == mtt_pkg::SLOT_FREE) begin
					rec_out.state = mtt_pkg::SLOT_ALLOC;
					flags.claim   = 1'b1;
				end
			end
			mtt_pkg::OP_FREE: begin
				if (cmd.hit) begin
					rec_out.state = mtt_pkg::SLOT_FREE;
				end
			end
			mtt_pkg::OP_INIT: begin
				if (cmd.hit) begin
					rec_out.dest = cmd.dest;
					rec_out.data = cmd.data;
				end
			end
			mtt_pkg::OP_SET_TIME: begin
				if (cmd.hit) begin
					rec_out.remaining = cmd.timeout;
					rec_out.state     = mtt_pkg::SLOT_RUN;
				end
			end
			mtt_pkg::OP_TICK: begin
				if (rec_in.state == mtt_pkg::SLOT_RUN) begin
					rec_out.remaining = dec;
					if (dec == '0) begin
						rec_out.state = mtt_pkg::SLOT_ALLOC;
						flags.expire  = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/multi_timer_table_core.sv
// ----------------------------------------------------------------------------
// multi_timer_table_core
// Countdown timer table; slot records rotate through a ring of cells and are
// updated one at a time as they pass the head.
// ----------------------------------------------------------------------------
// result: an item's last result follows one full turn of the ring and the
// flush state; a new item is taken only after the last one is done, the ring
//   making one full turn per item; a stalled result output can pause the ring
// reset: asynchronous, all slots free and tick count zero at once, no sweep
// ----------------------------------------------------------------------------
`default_nettype none

module multi_timer_table_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// timer_index[4:0], dest_id[12:5], event_data[20:13], timeout[52:21], pad
	input  wire  [55:0] s_axis_tdata,
	// op[2:0]
	input  wire  [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// status[1:0], slot[6:2], out_dest[14:7], out_data[22:15],
	// tick_count[54:23], pad
	output logic [55:0] m_axis_tdata,
	// kind[1:0]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} fsm_t;

	fsm_t                              state_q;
	logic [mtt_pkg::OpW-1:0]           op_q;
	logic [mtt_pkg::IdxW-1:0]          idx_q;
	logic [mtt_pkg::ByteW-1:0]         dest_q;
	logic [mtt_pkg::ByteW-1:0]         data_q;
	logic [mtt_pkg::CountW-1:0]        timeout_q;
	logic                              ok_q;
	logic [mtt_pkg::PosW-1:0]          pos_q;
	logic                              found_q;
	logic [mtt_pkg::PosW-1:0]          found_slot_q;
	logic                              pend_q;
	logic [mtt_pkg::PosW-1:0]          pend_slot_q;
	logic [mtt_pkg::ByteW-1:0]         pend_dest_q;
	logic [mtt_pkg::ByteW-1:0]         pend_data_q;
	logic [mtt_pkg::CountW-1:0]        ticks_q;

	logic                              out_valid_q;
	logic [mtt_pkg::KindW-1:0]         out_kind_q;
	logic [mtt_pkg::StatW-1:0]         out_status_q;
	logic [mtt_pkg::IdxW-1:0]          out_slot_q;
	logic [mtt_pkg::ByteW-1:0]         out_dest_q;
	logic [mtt_pkg::ByteW-1:0]         out_data_q;
	logic [mtt_pkg::CountW-1:0]        out_ticks_q;
	logic                              out_last_q;

	mtt_pkg::slot_rec_t                ring_rec [mtt_pkg::NumSlots];
	mtt_pkg::slot_rec_t                next_rec [mtt_pkg::NumSlots];
	mtt_pkg::slot_rec_t                head_rec;
	mtt_pkg::head_cmd_t                head_cmd;
	mtt_pkg::head_flags_t              head_flags;

	logic                              out_free;
	logic                              out_load;
	logic                              walk_stall;
	logic                              shift;
	logic                              last_pos;
	logic                              in_ok;

	logic [mtt_pkg::KindW-1:0]         fin_kind;
	logic [mtt_pkg::StatW-1:0]         fin_status;
	logic [mtt_pkg::IdxW-1:0]          fin_slot;
	logic [mtt_pkg::ByteW-1:0]         fin_dest;
	logic [mtt_pkg::ByteW-1:0]         fin_data;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_ok         = ({1'b0, s_axis_tdata[4:0]} <
		(mtt_pkg::IdxW+1)'(mtt_pkg::NumSlots));

	assign out_free   = !out_valid_q || m_axis_tready;
	// a second expiry needs the earlier one moved to the output first
	assign walk_stall = head_flags.expire && pend_q && !out_free;
	assign shift      = (state_q == ST_WALK) && !walk_stall;
	assign last_pos   = (pos_q == mtt_pkg::PosW'(mtt_pkg::NumSlots - 1));
	assign out_load   = (shift && head_flags.expire && pend_q) ||
		(state_q == ST_FLUSH && out_free);

	assign head_cmd.op      = op_q;
	assign head_cmd.hit     = ok_q && (idx_q == mtt_pkg::IdxW'(pos_q));
	assign head_cmd.found   = found_q;
	assign head_cmd.dest    = dest_q;
	assign head_cmd.data    = data_q;
	assign head_cmd.timeout = timeout_q;

	mtt_head u_head (
		.cmd     (head_cmd),
		.rec_in  (ring_rec[0]),
		.rec_out (head_rec),
		.flags   (head_flags)
	);

	// ring: every cell takes its upper neighbor, the top cell takes the head
	for (genvar i = 0; i < mtt_pkg::NumSlots; i++) begin : g_ring
		if (i == mtt_pkg::NumSlots - 1) begin : g_top
			assign next_rec[i] = head_rec;
		end else begin : g_mid
			assign next_rec[i] = ring_rec[i+1];
		end
		mtt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.rec_in  (next_rec[i]),
			.rec_out (ring_rec[i])
		);
	end

	// closing result of the pass
	always_comb begin
		fin_kind   = mtt_pkg::KIND_ACK;
		fin_status = mtt_pkg::STAT_OK;
		fin_slot   = '0;
		fin_dest   = '0;
		fin_data   = '0;
		case (op_q)
			mtt_pkg::OP_ALLOC: begin
				fin_kind = mtt_pkg::KIND_ALLOC;
				if (found_q) begin
					fin_slot = mtt_pkg::IdxW'(found_slot_q);
				end else begin
					fin_status = mtt_pkg::STAT_NO_FREE;
				end
			end
			mtt_pkg::OP_FREE, mtt_pkg::OP_INIT, mtt_pkg::OP_SET_TIME: begin
				if (!ok_q) begin
					fin_status = mtt_pkg::STAT_BAD_INDEX;
				end
			end
			mtt_pkg::OP_TICK: begin
				if (pend_q) begin
					fin_kind = mtt_pkg::KIND_EXPIRE;
					fin_slot = mtt_pkg::IdxW'(pend_slot_q);
					fin_dest = pend_dest_q;
					fin_data = pend_data_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= '0;
			idx_q        <= '0;
			dest_q       <= '0;
			data_q       <= '0;
			timeout_q    <= '0;
			ok_q         <= 1'b0;
			pos_q        <= '0;
			found_q      <= 1'b0;
			found_slot_q <= '0;
			pend_q       <= 1'b0;
			pend_slot_q  <= '0;
			pend_dest_q  <= '0;
			pend_data_q  <= '0;
			ticks_q      <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= '0;
			out_status_q <= '0;
			out_slot_q   <= '0;
			out_dest_q   <= '0;
			out_data_q   <= '0;
			out_ticks_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q      <= s_axis_tuser;
						idx_q     <= s_axis_tdata[4:0];
						dest_q    <= s_axis_tdata[12:5];
						data_q    <= s_axis_tdata[20:13];
						timeout_q <= s_axis_tdata[52:21];
						ok_q      <= in_ok;
						pos_q     <= '0;
						found_q   <= 1'b0;
						pend_q    <= 1'b0;
						if (s_axis_tuser == mtt_pkg::OP_TICK) begin
							ticks_q <= ticks_q + mtt_pkg::CountW'(1);
						end
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (shift) begin
						pos_q <= pos_q + mtt_pkg::PosW'(1);
						if (head_flags.claim) begin
							found_q      <= 1'b1;
							found_slot_q <= pos_q;
						end
						if (head_flags.expire) begin
							// hold the newest expiry back until we know if it is last
							if (pend_q) begin
								out_valid_q  <= 1'b1;
								out_kind_q   <= mtt_pkg::KIND_EXPIRE;
								out_status_q <= mtt_pkg::STAT_OK;
								out_slot_q   <= mtt_pkg::IdxW'(pend_slot_q);
								out_dest_q   <= pend_dest_q;
								out_data_q   <= pend_data_q;
								out_ticks_q  <= ticks_q;
								out_last_q   <= 1'b0;
							end
							pend_q      <= 1'b1;
							pend_slot_q <= pos_q;
							pend_dest_q <= ring_rec[0].dest;
							pend_data_q <= ring_rec[0].data;
						end
						if (last_pos) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= fin_kind;
						out_status_q <= fin_status;
						out_slot_q   <= fin_slot;
						out_dest_q   <= fin_dest;
						out_data_q   <= fin_data;
						out_ticks_q  <= ticks_q;
						out_last_q   <= 1'b1;
						pend_q       <= 1'b0;
						pos_q        <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {1'b0, out_ticks_q, out_data_q, out_dest_q, out_slot_q,
		out_status_q};

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again right after a beat");

	a_ring_parked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> pos_q == '0)
		else $error("ring not aligned while idle");

	a_only_expiry_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == mtt_pkg::KIND_EXPIRE)
		else $error("non-final result that is not an expiry");

	a_pend_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> state_q != ST_IDLE && op_q == mtt_pkg::OP_TICK)
		else $error("held expiry outside a tick pass");

endmodule

`default_nettype wire
